>>> hdl/pbe_pkg.sv
package pbe_pkg;

    localparam int DIV_NW = 25;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic [3:0] SEG_PTS_RESET = 4'd4;
    localparam logic [3:0] SEG_PTS_MIN   = 4'd3;
    localparam logic [3:0] SEG_PTS_MAX   = 4'd9;
    localparam logic [3:0] SEG_LAST      = 4'd15;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;

endpackage

>>> hdl/piecewise_bezier_evaluator_core.sv
// channel   | direction | handshake            | word
// input     | in        | i_valid / o_ready    | i_op, i_px, i_py, i_pz, i_curve_param
// result    | out       | o_valid / i_ready    | o_cx, o_cy, o_cz, o_status
// config    | in        | i_cfg_we             | i_cfg_data
// One word at a time; o_ready is high only while the sequencer idles.
// Add: a divider pass for the knot test, plus a knot rewrite when the test hits.
// Evaluate: one or two divider passes, the powers of (1-u), then a pass per
// segment point on the shared 32x32 multiplier (n+1 points, n <= 15).
// A finished result waits in the output register while the next word is taken.
// Reset (synchronous, i_rst_n low) empties the point store and sets segment_points to 4.
module piecewise_bezier_evaluator_core #(
    parameter int MAX_POINTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [31:0] i_px,
    input  logic [31:0] i_py,
    input  logic [31:0] i_pz,
    input  logic [16:0] i_curve_param,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_cx,
    output logic [31:0] o_cy,
    output logic [31:0] o_cz,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = (CW + 4 > 12) ? CW + 4 : 12;
    localparam int NW = pbe_pkg::DIV_NW;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_ADIV, S_AR1, S_AR2, S_AR3, S_AWR,
        S_QDIV, S_SEG, S_CAP, S_UDIV, S_VINIT, S_VMUL, S_VPUSH,
        S_W1, S_W2, S_W3, S_W4, S_X, S_Y, S_Z, S_U, S_UN, S_FIN, S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [3:0]          r_seg_pts;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_knot;
    logic                r_op;
    logic [31:0]         r_px, r_py, r_pz;
    logic [16:0]         r_cp;
    logic [SW-1:0]       r_pb, r_pe;
    logic [3:0]          r_n, r_j, r_i;
    logic [16:0]         r_u;
    logic [30:0]         r_up;
    logic [30:0]         r_vs [16];
    logic [12:0]         r_row [16];
    logic signed [63:0]  r_prod;
    logic [30:0]         r_t, r_w;
    logic [31:0]         r_mx, r_my, r_mz;
    logic signed [63:0]  r_accx, r_accy, r_accz;
    logic [31:0]         r_rx, r_ry, r_rz;
    logic [1:0]          r_rst;
    logic                r_ovalid;
    logic [31:0]         r_ocx, r_ocy, r_ocz;
    logic [1:0]          r_ostat;

    logic [3:0]          sp, span;
    logic [AW-1:0]       k_lo, k_hi, k_mid;
    logic [AW-1:0]       ram_raddr, ram_waddr;
    logic                ram_we;
    logic [31:0]         ram_wx, ram_wy, ram_wz;
    logic [31:0]         rd_x, rd_y, rd_z;
    logic                div_start, div_done;
    logic [NW-1:0]       div_num, div_quot;
    logic [CW-1:0]       div_den, div_rem;
    logic [CW-1:0]       cnt_m1;
    logic                add_knot;
    logic [SW-1:0]       seg_pe0, ksp, kspan, cnt_m1_s, pb_ov;
    logic                seg_ov;
    logic [SW-1:0]       seg_d;
    logic [3:0]          cap_n;
    logic [SW+7:0]       pb256, cp_ext;
    logic [SW+7:0]       cp_diff;
    logic                zero_u;
    logic [16:0]         v;
    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  mul_p;
    logic signed [63:0]  rnd16, rnd30;

    function automatic logic [31:0] mean2(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) + $signed({b[31], b});
        return s[32:1];
    endfunction

    function automatic logic [31:0] finish(input logic signed [63:0] acc);
        logic signed [64:0] s;
        logic signed [34:0] q;
        s = $signed({acc[63], acc}) + 65'sd536870912;
        q = s[64:30];
        if (q > 35'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (q < -35'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return q[31:0];
        end
    endfunction

    always_comb begin
        if (r_seg_pts < pbe_pkg::SEG_PTS_MIN) begin
            sp = pbe_pkg::SEG_PTS_MIN;
        end else if (r_seg_pts > pbe_pkg::SEG_PTS_MAX) begin
            sp = pbe_pkg::SEG_PTS_MAX;
        end else begin
            sp = r_seg_pts;
        end
        span = sp - 4'd1;

        k_mid  = r_cnt[AW-1:0] - AW'(span);
        k_lo   = k_mid - AW'(1);
        k_hi   = k_mid + AW'(1);
        cnt_m1 = r_cnt - CW'(1);

        add_knot = (div_rem == '0) && (r_cnt > CW'(span));

        seg_pe0  = r_pb + SW'(span);
        ksp      = SW'(r_knot) * SW'(sp);
        kspan    = SW'(r_knot) * SW'(span);
        cnt_m1_s = SW'(cnt_m1);
        seg_ov   = (seg_pe0 > ksp) || (seg_pe0 > cnt_m1_s);
        pb_ov    = (kspan > cnt_m1_s) ? cnt_m1_s : kspan;

        seg_d   = r_pe - r_pb;
        cap_n   = (seg_d > SW'(pbe_pkg::SEG_LAST)) ? pbe_pkg::SEG_LAST : seg_d[3:0];
        pb256   = {r_pb, 8'd0};
        cp_ext  = (SW+8)'(r_cp);
        cp_diff = cp_ext - pb256;
        zero_u  = (cap_n == 4'd0) || (cp_ext <= pb256);

        v = pbe_pkg::ONE_Q16 - r_u;
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (r_state)
            S_DISP: begin
                if (r_op == pbe_pkg::OP_ADD) begin
                    div_start = (r_cnt < CW'(MAX_POINTS));
                    div_num   = NW'(r_cnt);
                    div_den   = CW'(span);
                end else if (r_knot == '0) begin
                    div_start = (r_cnt != '0);
                    div_num   = {r_cp, 8'd0};
                    div_den   = r_cnt;
                end else begin
                    div_start = (r_cnt != '0);
                    div_num   = NW'(r_cp[16:8]);
                    div_den   = CW'(span);
                end
            end
            S_CAP: begin
                div_start = !zero_u;
                div_num   = {cp_diff[16:0], 8'd0};
                div_den   = CW'(cap_n);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_wx    = r_px;
        ram_wy    = r_py;
        ram_wz    = r_pz;
        case (r_state)
            S_AR1:   ram_raddr = k_lo;
            S_AR2:   ram_raddr = k_hi;
            default: ram_raddr = r_pb[AW-1:0] + AW'(r_i);
        endcase
        case (r_state)
            S_AR3: begin
                ram_we    = 1'b1;
                ram_waddr = k_mid;
                ram_wx    = mean2(r_mx, rd_x);
                ram_wy    = mean2(r_my, rd_y);
                ram_wz    = mean2(r_mz, rd_z);
            end
            S_AWR: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_VMUL: begin
                mul_a = $signed({1'b0, r_vs[0]});
                mul_b = $signed({15'd0, v});
            end
            S_W1: begin
                mul_a = $signed({1'b0, r_up});
                mul_b = $signed({1'b0, r_vs[0]});
            end
            S_W3: begin
                mul_a = $signed({19'd0, r_row[0]});
                mul_b = $signed({1'b0, r_t});
            end
            S_X: begin
                mul_a = $signed(rd_x);
                mul_b = $signed({1'b0, r_w});
            end
            S_Y: begin
                mul_a = $signed(rd_y);
                mul_b = $signed({1'b0, r_w});
            end
            S_Z: begin
                mul_a = $signed(rd_z);
                mul_b = $signed({1'b0, r_w});
            end
            S_U: begin
                mul_a = $signed({1'b0, r_up});
                mul_b = $signed({15'd0, r_u});
            end
            default: begin
                mul_a = '0;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
        rnd16 = r_prod + 64'sd32768;
        rnd30 = r_prod + 64'sd536870912;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_DISP;
            S_DISP: begin
                if (r_op == pbe_pkg::OP_ADD) begin
                    n_state = (r_cnt < CW'(MAX_POINTS)) ? S_ADIV : S_DONE;
                end else if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = (r_knot == '0) ? S_UDIV : S_QDIV;
                end
            end
            S_ADIV:  if (div_done) n_state = add_knot ? S_AR1 : S_AWR;
            S_AR1:   n_state = S_AR2;
            S_AR2:   n_state = S_AR3;
            S_AR3:   n_state = S_AWR;
            S_AWR:   n_state = S_DONE;
            S_QDIV:  if (div_done) n_state = S_SEG;
            S_SEG:   n_state = S_CAP;
            S_CAP:   n_state = zero_u ? S_VINIT : S_UDIV;
            S_UDIV:  if (div_done) n_state = S_VINIT;
            S_VINIT: n_state = (r_n == 4'd0) ? S_W1 : S_VMUL;
            S_VMUL:  n_state = S_VPUSH;
            S_VPUSH: n_state = (r_j + 4'd1 == r_n) ? S_W1 : S_VMUL;
            S_W1:    n_state = S_W2;
            S_W2:    n_state = S_W3;
            S_W3:    n_state = S_W4;
            S_W4:    n_state = S_X;
            S_X:     n_state = S_Y;
            S_Y:     n_state = S_Z;
            S_Z:     n_state = S_U;
            S_U:     n_state = S_UN;
            S_UN:    n_state = (r_i == r_n) ? S_FIN : S_W1;
            S_FIN:   n_state = S_DONE;
            S_DONE:  if (!r_ovalid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seg_pts <= pbe_pkg::SEG_PTS_RESET;
            r_cnt     <= '0;
            r_knot    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_prod  <= mul_p;
            if (i_cfg_we) begin
                r_seg_pts <= i_cfg_data;
            end
            if (i_ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_op <= i_op;
                    r_px <= i_px;
                    r_py <= i_py;
                    r_pz <= i_pz;
                    r_cp <= i_curve_param;
                end
                S_DISP: begin
                    r_rx  <= '0;
                    r_ry  <= '0;
                    r_rz  <= '0;
                    r_rst <= pbe_pkg::ST_OK;
                    r_pb  <= '0;
                    r_n   <= (cnt_m1 > CW'(pbe_pkg::SEG_LAST)) ? pbe_pkg::SEG_LAST
                                                                : cnt_m1[3:0];
                    if (r_op == pbe_pkg::OP_ADD) begin
                        if (r_cnt >= CW'(MAX_POINTS)) r_rst <= pbe_pkg::ST_FULL;
                    end else if (r_cnt == '0) begin
                        r_rst <= pbe_pkg::ST_EMPTY;
                    end
                end
                S_AR2: begin
                    r_mx <= rd_x;
                    r_my <= rd_y;
                    r_mz <= rd_z;
                end
                S_AR3: begin
                    r_knot <= r_knot + CW'(1);
                end
                S_AWR: begin
                    r_cnt <= r_cnt + CW'(1);
                end
                S_QDIV: begin
                    r_pb <= SW'(div_quot[8:0]) * SW'(span);
                end
                S_SEG: begin
                    if (seg_ov) begin
                        r_pb <= pb_ov;
                        r_pe <= cnt_m1_s;
                    end else begin
                        r_pe <= seg_pe0;
                    end
                end
                S_CAP: begin
                    r_n <= cap_n;
                    r_u <= '0;
                end
                S_UDIV: begin
                    if (div_done) begin
                        r_u <= (div_quot > NW'(pbe_pkg::ONE_Q16)) ? pbe_pkg::ONE_Q16
                                                                  : div_quot[16:0];
                    end
                end
                S_VINIT: begin
                    r_vs[0] <= pbe_pkg::ONE_Q30;
                    for (int k = 1; k < 16; k++) begin
                        r_vs[k]  <= r_vs[k-1];
                        r_row[k] <= '0;
                    end
                    r_row[0] <= 13'd1;
                    r_j      <= '0;
                    r_i      <= '0;
                    r_up     <= pbe_pkg::ONE_Q30;
                    r_accx   <= '0;
                    r_accy   <= '0;
                    r_accz   <= '0;
                end
                S_VPUSH: begin
                    r_vs[0] <= rnd16[46:16];
                    for (int k = 1; k < 16; k++) begin
                        r_vs[k]  <= r_vs[k-1];
                        r_row[k] <= r_row[k] + r_row[k-1];
                    end
                    r_j <= r_j + 4'd1;
                end
                S_W1: begin
                    for (int k = 0; k < 15; k++) begin
                        r_vs[k] <= r_vs[k+1];
                    end
                end
                S_W2: begin
                    r_t <= rnd30[60:30];
                end
                S_W4: begin
                    r_w <= (r_prod > 64'sd1073741824) ? pbe_pkg::ONE_Q30 : r_prod[30:0];
                end
                S_Y: begin
                    r_accx <= r_accx + r_prod;
                end
                S_Z: begin
                    r_accy <= r_accy + r_prod;
                end
                S_U: begin
                    r_accz <= r_accz + r_prod;
                end
                S_UN: begin
                    r_up <= rnd16[46:16];
                    for (int k = 0; k < 15; k++) begin
                        r_row[k] <= r_row[k+1];
                    end
                    r_i <= r_i + 4'd1;
                end
                S_FIN: begin
                    r_rx <= finish(r_accx);
                    r_ry <= finish(r_accy);
                    r_rz <= finish(r_accz);
                end
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_ocx    <= r_rx;
                        r_ocy    <= r_ry;
                        r_ocz    <= r_rz;
                        r_ostat  <= r_rst;
                    end
                end
                default: begin
                    r_j <= r_j;
                end
            endcase
        end
    end

    pbe_div #(
        .NW (NW),
        .DW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    pbe_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wx),
        .i_raddr (ram_raddr),
        .o_rdata (rd_x)
    );

    pbe_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wy),
        .i_raddr (ram_raddr),
        .o_rdata (rd_y)
    );

    pbe_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_z (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wz),
        .i_raddr (ram_raddr),
        .o_rdata (rd_z)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_cx     = r_ocx;
    assign o_cy     = r_ocy;
    assign o_cz     = r_ocz;
    assign o_status = r_ostat;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while a word is in work");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS))
        else $error("point count past store depth");

    a_knot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_knot <= r_cnt)
        else $error("knot count past point count");

    a_read_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_X) |-> (CW'(ram_raddr) < r_cnt))
        else $error("segment read beyond stored points");

endmodule

>>> hdl/pbe_ram.sv
module pbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/pbe_div.sv
module pbe_div #(
    parameter int NW = 25,
    parameter int DW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);

    localparam int KW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_left;
    logic [NW-1:0] r_quot;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   shifted;
    logic          ge;
    logic [DW:0]   diff;

    always_comb begin
        shifted = {r_rem, r_quot[NW-1]};
        ge      = (shifted >= {1'b0, r_den});
        diff    = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= KW'(NW);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quot <= {r_quot[NW-2:0], ge};
                r_rem  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
                r_left <= r_left - 1'b1;
                if (r_left == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule
